FILE: rtl/rcktm_pkg.sv
package rcktm_pkg;

    localparam int DEFAULT_MAX_PIXELS = 65536;
    localparam int DEFAULT_MAX_SIDE   = 256;

    localparam int QUEUE_DEPTH        = 2;
    localparam int RESULT_DEPTH       = 2;

    localparam int TEXEL_W            = 8;
    localparam int ADDR_W             = 16;
    localparam int DIM_W              = 9;
    localparam int SCALE_W            = 5;
    localparam int RES_W              = TEXEL_W + 2;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 5;

    // register indexes (byte address 4*i)
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_SCALE_DIVISOR = 3'd2;
    localparam logic [2:0] REG_ROTATION_MODE = 3'd3;
    localparam logic [2:0] REG_KEY_COLOR     = 3'd4;

    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH   = 9'd64;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT  = 9'd64;
    localparam logic [SCALE_W-1:0] RST_SCALE_DIVISOR = 5'd1;
    localparam logic [TEXEL_W-1:0] RST_KEY_COLOR     = 8'd255;

    typedef enum logic [1:0] {
        CMD_LOAD_LOWER = 2'd0,
        CMD_LOAD_UPPER = 2'd1,
        CMD_EMIT       = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ROT_NONE          = 2'd0,
        ROT_QUARTER       = 2'd1,
        ROT_HALF          = 2'd2,
        ROT_THREE_QUARTER = 2'd3
    } t_rot;

    typedef struct packed {
        t_cmd kind;
        logic scaled;
        logic last;
    } t_item_ctrl;

endpackage

FILE: rtl/rcktm_fifo.sv
module rcktm_fifo #(
    parameter int WIDTH = rcktm_pkg::RES_W,
    parameter int DEPTH = rcktm_pkg::QUEUE_DEPTH,
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTRW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTRW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTRW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/rcktm_front.sv
module rcktm_front #(
    parameter int MAX_PIXELS = rcktm_pkg::DEFAULT_MAX_PIXELS,
    parameter int MAX_SIDE   = rcktm_pkg::DEFAULT_MAX_SIDE,
    localparam int AW  = $clog2(MAX_PIXELS),
    localparam int CW  = $clog2(MAX_SIDE),
    localparam int SW  = $clog2(MAX_SIDE + 1),
    localparam int NW  = $clog2(MAX_SIDE * MAX_SIDE),
    localparam int QW  = $bits(rcktm_pkg::t_item_ctrl) + AW + rcktm_pkg::TEXEL_W + 2 * NW + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [1:0]                     i_command,
    input  logic [rcktm_pkg::ADDR_W-1:0]   i_texel_address,
    input  logic [rcktm_pkg::TEXEL_W-1:0]  i_texel_value,
    output logic                           o_full,
    input  logic [SW-1:0]                  i_width,
    input  logic [SW-1:0]                  i_height,
    input  rcktm_pkg::t_rot                i_rotation,
    output logic                           o_q_push,
    output logic [QW-1:0]                  o_q_data,
    input  logic                           i_q_full
);

    localparam int PW  = SW + CW + 3;
    localparam int LPW = SW + CW + 1;

    logic                          r_f_valid, n_f_valid;
    rcktm_pkg::t_item_ctrl         r_f_ctrl;
    logic [AW-1:0]                 r_f_addr;
    logic [rcktm_pkg::TEXEL_W-1:0] r_f_value;
    logic signed [CW:0]            r_f_umul;
    logic [CW-1:0]                 r_f_uadd;
    logic [CW-1:0]                 r_f_x, r_f_y;
    logic [CW-1:0]                 r_col, n_col;
    logic [CW-1:0]                 r_row, n_row;

    logic                          accept, keep, is_emit;
    rcktm_pkg::t_item_ctrl         ctrl;
    logic [CW-1:0]                 x0, y0;
    logic signed [31:0]            umul_t;
    logic [31:0]                   uadd_t;
    logic signed [PW-1:0]          up_full;
    logic [LPW-1:0]                lo_full;

    assign o_full = r_f_valid && i_q_full;
    assign accept = i_push && !o_full;

    // raster position, wrapping first if the frame shrank
    assign x0 = (32'(r_col) >= 32'(i_width))  ? '0 : r_col;
    assign y0 = (32'(r_row) >= 32'(i_height)) ? '0 : r_row;

    always_comb begin
        keep    = 1'b0;
        is_emit = 1'b0;
        case (rcktm_pkg::t_cmd'(i_command))
            rcktm_pkg::CMD_LOAD_LOWER,
            rcktm_pkg::CMD_LOAD_UPPER: begin
                keep = (32'(i_texel_address) < 32'(MAX_PIXELS));
            end
            rcktm_pkg::CMD_EMIT: begin
                keep    = 1'b1;
                is_emit = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        ctrl.kind   = rcktm_pkg::t_cmd'(i_command);
        ctrl.scaled = (i_rotation != rcktm_pkg::ROT_THREE_QUARTER);
        ctrl.last   = (32'(x0) + 32'd1 == 32'(i_width)) && (32'(y0) + 32'd1 == 32'(i_height));
        case (i_rotation)
            rcktm_pkg::ROT_NONE: begin
                umul_t = $signed(32'(y0));
                uadd_t = 32'(x0);
            end
            rcktm_pkg::ROT_QUARTER: begin
                umul_t = $signed(32'(x0));
                uadd_t = 32'(i_height) - 32'd1 - 32'(y0);
            end
            rcktm_pkg::ROT_HALF: begin
                umul_t = $signed(32'(i_height)) - 32'sd1 - $signed(32'(y0));
                uadd_t = 32'(i_width) - 32'd1 - 32'(x0);
            end
            default: begin
                // may go negative when the frame is wider than it is high
                umul_t = $signed(32'(i_height)) - 32'sd1 - $signed(32'(x0));
                uadd_t = 32'(y0);
            end
        endcase
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept && is_emit) begin
            if (32'(x0) + 32'd1 >= 32'(i_width)) begin
                n_col = '0;
                n_row = (32'(y0) + 32'd1 >= 32'(i_height)) ? '0 : y0 + 1'b1;
            end else begin
                n_col = x0 + 1'b1;
                n_row = y0;
            end
        end
    end

    assign n_f_valid = (accept && keep) || (r_f_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_f_valid <= n_f_valid;
            r_col     <= n_col;
            r_row     <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_ctrl  <= ctrl;
            r_f_addr  <= AW'(i_texel_address);
            r_f_value <= i_texel_value;
            r_f_umul  <= umul_t[CW:0];
            r_f_uadd  <= uadd_t[CW-1:0];
            r_f_x     <= x0;
            r_f_y     <= y0;
        end
    end

    // linear source numerators
    assign up_full = $signed({1'b0, i_width}) * r_f_umul + $signed({1'b0, r_f_uadd});
    assign lo_full = LPW'(i_width) * LPW'(r_f_y) + LPW'(r_f_x);

    assign o_q_push = r_f_valid;
    assign o_q_data = {r_f_ctrl, r_f_addr, r_f_value, up_full[NW:0], lo_full[NW-1:0]};

endmodule

FILE: rtl/rcktm_back.sv
module rcktm_back #(
    parameter int MAX_PIXELS = rcktm_pkg::DEFAULT_MAX_PIXELS,
    parameter int MAX_SIDE   = rcktm_pkg::DEFAULT_MAX_SIDE,
    localparam int AW  = $clog2(MAX_PIXELS),
    localparam int NW  = $clog2(MAX_SIDE * MAX_SIDE),
    localparam int QW  = $bits(rcktm_pkg::t_item_ctrl) + AW + rcktm_pkg::TEXEL_W + 2 * NW + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [QW-1:0]                  i_q_data,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  logic [rcktm_pkg::SCALE_W-1:0]  i_scale,
    input  logic [rcktm_pkg::TEXEL_W-1:0]  i_key,
    output logic                           o_res_push,
    output logic [rcktm_pkg::RES_W-1:0]    o_res_data,
    input  logic                           i_res_full
);

    localparam int RADIX     = 4;
    localparam int DIV_STEPS = (NW + RADIX - 1) / RADIX;
    localparam int DVW       = DIV_STEPS * RADIX;
    localparam int STW       = $clog2(DIV_STEPS + 1);
    localparam int RW        = rcktm_pkg::SCALE_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_ADDR  = 6'b000100,
        ST_UPCHK = 6'b001000,
        ST_LOCHK = 6'b010000,
        ST_OUT   = 6'b100000
    } t_back_state;

    t_back_state                   r_state, n_state;
    logic [DVW-1:0]                r_dvd_up, n_dvd_up, r_dvd_lo, n_dvd_lo;
    logic [RW-1:0]                 r_rem_up, n_rem_up, r_rem_lo, n_rem_lo;
    logic [STW-1:0]                r_step, n_step;
    logic [NW:0]                   r_up_idx, n_up_idx;
    logic [NW-1:0]                 r_lo_idx, n_lo_idx;
    logic                          r_up_bad, n_up_bad, r_lo_bad, n_lo_bad;
    logic                          r_last, n_last;
    logic                          r_err, n_err;
    logic [rcktm_pkg::TEXEL_W-1:0] r_pix, n_pix;
    logic [rcktm_pkg::TEXEL_W-1:0] r_up_q, r_lo_q;

    logic [rcktm_pkg::TEXEL_W-1:0] r_upper_mem [MAX_PIXELS];
    logic [rcktm_pkg::TEXEL_W-1:0] r_lower_mem [MAX_PIXELS];

    rcktm_pkg::t_item_ctrl         q_ctrl;
    logic [AW-1:0]                 q_addr;
    logic [rcktm_pkg::TEXEL_W-1:0] q_value;
    logic [NW:0]                   q_up_num;
    logic [NW-1:0]                 q_lo_num;

    logic [DVW-1:0]                div_up_nx, div_lo_nx;
    logic [RW-1:0]                 rem_up_nx, rem_lo_nx;
    logic                          up_bad, lo_bad;
    logic [rcktm_pkg::TEXEL_W-1:0] up_pix;
    logic                          up_we, lo_we;

    assign {q_ctrl, q_addr, q_value, q_up_num, q_lo_num} = i_q_data;

    function automatic logic [RW:0] f_div_step(input logic [RW-1:0] rem, input logic din,
                                               input logic [RW-1:0] dvs);
        logic [RW:0] t;
        t = {rem, din};
        if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
            return {t[RW-1:0], 1'b1};
        end
        return {t[RW-1:0], 1'b0};
    endfunction

    // restoring division, RADIX quotient bits per cycle; quotient shifts into the dividend
    always_comb begin
        logic [RW:0] res;
        rem_up_nx = r_rem_up;
        rem_lo_nx = r_rem_lo;
        div_up_nx = r_dvd_up;
        div_lo_nx = r_dvd_lo;
        for (int i = 0; i < RADIX; i++) begin
            res       = f_div_step(rem_up_nx, div_up_nx[DVW-1], i_scale);
            rem_up_nx = res[RW:1];
            div_up_nx = {div_up_nx[DVW-2:0], res[0]};
            res       = f_div_step(rem_lo_nx, div_lo_nx[DVW-1], i_scale);
            rem_lo_nx = res[RW:1];
            div_lo_nx = {div_lo_nx[DVW-2:0], res[0]};
        end
    end

    assign up_bad = r_up_idx[NW] || (32'(r_up_idx[NW-1:0]) >= 32'(MAX_PIXELS));
    assign lo_bad = (32'(r_lo_idx) >= 32'(MAX_PIXELS));
    assign up_pix = r_up_bad ? i_key : r_up_q;

    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign up_we      = o_q_pop && (q_ctrl.kind == rcktm_pkg::CMD_LOAD_UPPER);
    assign lo_we      = o_q_pop && (q_ctrl.kind == rcktm_pkg::CMD_LOAD_LOWER);
    assign o_res_push = (r_state == ST_OUT);
    assign o_res_data = {r_pix, r_last, r_err};

    always_comb begin
        n_state  = r_state;
        n_dvd_up = r_dvd_up;
        n_dvd_lo = r_dvd_lo;
        n_rem_up = r_rem_up;
        n_rem_lo = r_rem_lo;
        n_step   = r_step;
        n_up_idx = r_up_idx;
        n_lo_idx = r_lo_idx;
        n_up_bad = r_up_bad;
        n_lo_bad = r_lo_bad;
        n_last   = r_last;
        n_err    = r_err;
        n_pix    = r_pix;
        case (r_state)
            ST_IDLE: begin
                if (o_q_pop && (q_ctrl.kind == rcktm_pkg::CMD_EMIT)) begin
                    n_last = q_ctrl.last;
                    if (q_ctrl.scaled) begin
                        n_dvd_up = DVW'(q_up_num[NW-1:0]);
                        n_dvd_lo = DVW'(q_lo_num);
                        n_rem_up = '0;
                        n_rem_lo = '0;
                        n_step   = '0;
                        n_state  = ST_DIV;
                    end else begin
                        n_up_idx = q_up_num;
                        n_lo_idx = q_lo_num;
                        n_state  = ST_ADDR;
                    end
                end
            end
            ST_DIV: begin
                n_dvd_up = div_up_nx;
                n_dvd_lo = div_lo_nx;
                n_rem_up = rem_up_nx;
                n_rem_lo = rem_lo_nx;
                n_step   = r_step + 1'b1;
                if (r_step == STW'(DIV_STEPS - 1)) begin
                    n_up_idx = {1'b0, div_up_nx[NW-1:0]};
                    n_lo_idx = div_lo_nx[NW-1:0];
                    n_state  = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_up_bad = up_bad;
                n_lo_bad = lo_bad;
                n_state  = ST_UPCHK;
            end
            ST_UPCHK: begin
                n_err = r_up_bad;
                if (up_pix == i_key) begin
                    n_state = ST_LOCHK;
                end else begin
                    n_pix   = up_pix;
                    n_state = ST_OUT;
                end
            end
            ST_LOCHK: begin
                n_pix   = r_lo_bad ? i_key : r_lo_q;
                n_err   = r_err || r_lo_bad;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd_up <= n_dvd_up;
        r_dvd_lo <= n_dvd_lo;
        r_rem_up <= n_rem_up;
        r_rem_lo <= n_rem_lo;
        r_step   <= n_step;
        r_up_idx <= n_up_idx;
        r_lo_idx <= n_lo_idx;
        r_up_bad <= n_up_bad;
        r_lo_bad <= n_lo_bad;
        r_last   <= n_last;
        r_err    <= n_err;
        r_pix    <= n_pix;
    end

    always_ff @(posedge i_clk) begin
        if (up_we) begin
            r_upper_mem[q_addr] <= q_value;
        end
        if (r_state == ST_ADDR) begin
            r_up_q <= r_upper_mem[AW'(r_up_idx[NW-1:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (lo_we) begin
            r_lower_mem[q_addr] <= q_value;
        end
        if (r_state == ST_UPCHK) begin
            r_lo_q <= r_lower_mem[AW'(r_lo_idx)];
        end
    end

endmodule

FILE: rtl/rotated_color_key_texture_merge_core.sv
// Colour-key merge of two palette textures, upper one rotated.
// Input channel (push/full): command, texel_address, texel_value. Load commands
// write the lower or upper store; emit commands produce one merged pixel each,
// walking the frame in raster order. Unknown commands and loads past the
// store are dropped. Result channel (empty/pop): merged_pixel, frame_last,
// index_error, oldest first; a two-entry result queue sits at the output.
// Loads are taken one per cycle while full is low. In rotations 0 to 2 an emit
// passes through the back end's radix-16 divider, an address check and a
// registered read of the upper store, plus a registered read of the lower
// store when the upper texel is transparent. Rotation three skips the divider.
// The back end takes the next command only once the current emit is done, and
// a registered front stage sits ahead of the command queue.
// A stalled receiver fills the result queue, the back end then holds its
// finished pixel and the command queue backs up to full.
// Reset (i_rst_n, synchronous) empties both queues, zeroes the raster
// counters and returns the APB registers to their defaults; store contents
// are left as they are and must be written before they are read.
module rotated_color_key_texture_merge_core #(
    parameter int MAX_PIXELS = rcktm_pkg::DEFAULT_MAX_PIXELS,
    parameter int MAX_SIDE   = rcktm_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_command,
    input  logic [rcktm_pkg::ADDR_W-1:0]      i_texel_address,
    input  logic [rcktm_pkg::TEXEL_W-1:0]     i_texel_value,
    output logic                              empty,
    input  logic                              pop,
    output logic [rcktm_pkg::TEXEL_W-1:0]     o_merged_pixel,
    output logic                              o_frame_last,
    output logic                              o_index_error,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rcktm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rcktm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rcktm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int NW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int QW = $bits(rcktm_pkg::t_item_ctrl) + AW + rcktm_pkg::TEXEL_W + 2 * NW + 1;

    logic [rcktm_pkg::DIM_W-1:0]   r_frame_width, r_frame_height;
    logic [rcktm_pkg::SCALE_W-1:0] r_scale_divisor;
    rcktm_pkg::t_rot               r_rotation_mode;
    logic [rcktm_pkg::TEXEL_W-1:0] r_key_color;

    logic                          cfg_wr;
    logic [2:0]                    reg_idx;
    logic [SW-1:0]                 width_eff, height_eff;
    logic [rcktm_pkg::SCALE_W-1:0] scale_eff;

    logic                          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0]                 q_wdata, q_rdata;
    logic                          res_push, res_full;
    logic [rcktm_pkg::RES_W-1:0]   res_wdata, res_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= rcktm_pkg::RST_FRAME_WIDTH;
            r_frame_height  <= rcktm_pkg::RST_FRAME_HEIGHT;
            r_scale_divisor <= rcktm_pkg::RST_SCALE_DIVISOR;
            r_rotation_mode <= rcktm_pkg::ROT_NONE;
            r_key_color     <= rcktm_pkg::RST_KEY_COLOR;
        end else if (cfg_wr) begin
            case (reg_idx)
                rcktm_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[rcktm_pkg::DIM_W-1:0];
                end
                rcktm_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[rcktm_pkg::DIM_W-1:0];
                end
                rcktm_pkg::REG_SCALE_DIVISOR: begin
                    r_scale_divisor <= pwdata[rcktm_pkg::SCALE_W-1:0];
                end
                rcktm_pkg::REG_ROTATION_MODE: begin
                    r_rotation_mode <= rcktm_pkg::t_rot'(pwdata[1:0]);
                end
                rcktm_pkg::REG_KEY_COLOR: begin
                    r_key_color <= pwdata[rcktm_pkg::TEXEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rcktm_pkg::REG_FRAME_WIDTH:   prdata = 32'(r_frame_width);
            rcktm_pkg::REG_FRAME_HEIGHT:  prdata = 32'(r_frame_height);
            rcktm_pkg::REG_SCALE_DIVISOR: prdata = 32'(r_scale_divisor);
            rcktm_pkg::REG_ROTATION_MODE: prdata = 32'(r_rotation_mode);
            rcktm_pkg::REG_KEY_COLOR:     prdata = 32'(r_key_color);
            default:                      prdata = '0;
        endcase
    end

    // zero acts as one, oversize as the largest side
    always_comb begin
        if (r_frame_width == '0) begin
            width_eff = SW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_SIDE)) begin
            width_eff = SW'(MAX_SIDE);
        end else begin
            width_eff = SW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            height_eff = SW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_SIDE)) begin
            height_eff = SW'(MAX_SIDE);
        end else begin
            height_eff = SW'(r_frame_height);
        end
    end

    assign scale_eff = (r_scale_divisor == '0) ? rcktm_pkg::SCALE_W'(1) : r_scale_divisor;

    rcktm_front #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_command       (i_command),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .o_full          (full),
        .i_width         (width_eff),
        .i_height        (height_eff),
        .i_rotation      (r_rotation_mode),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata),
        .i_q_full        (q_full)
    );

    rcktm_fifo #(
        .WIDTH (QW),
        .DEPTH (rcktm_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    rcktm_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (q_rdata),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_scale    (scale_eff),
        .i_key      (r_key_color),
        .o_res_push (res_push),
        .o_res_data (res_wdata),
        .i_res_full (res_full)
    );

    rcktm_fifo #(
        .WIDTH (rcktm_pkg::RES_W),
        .DEPTH (rcktm_pkg::RESULT_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign {o_merged_pixel, o_frame_last, o_index_error} = res_rdata;

endmodule

FILE: test/tb_rotated_color_key_texture_merge_core.sv
module tb_rotated_color_key_texture_merge_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_PIX        = rcktm_pkg::DEFAULT_MAX_PIXELS;
    localparam int          MAX_SIDE_LEN   = rcktm_pkg::DEFAULT_MAX_SIDE;
    localparam int          TEX_W          = rcktm_pkg::TEXEL_W;
    localparam int          ADR_W          = rcktm_pkg::ADDR_W;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 20;

    // Mirror of the merge engine: both texture stores, raster position and registers.
    class merge_scoreboard;
        typedef struct packed {
            logic [TEX_W-1:0] pixel;
            logic             last;
            logic             err;
        } t_pixel;

        bit [TEX_W-1:0] lower_tex[int];
        bit [TEX_W-1:0] upper_tex[int];
        int             col;
        int             row;
        int             width_reg;
        int             height_reg;
        int             scale_reg;
        int             rot_reg;
        int             key_reg;
        t_pixel         due[$];
        int             errors;

        function new();
            col        = 0;
            row        = 0;
            width_reg  = rcktm_pkg::RST_FRAME_WIDTH;
            height_reg = rcktm_pkg::RST_FRAME_HEIGHT;
            scale_reg  = rcktm_pkg::RST_SCALE_DIVISOR;
            rot_reg    = rcktm_pkg::ROT_NONE;
            key_reg    = rcktm_pkg::RST_KEY_COLOR;
            errors     = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                rcktm_pkg::REG_FRAME_WIDTH:   width_reg  = v[8:0];
                rcktm_pkg::REG_FRAME_HEIGHT:  height_reg = v[8:0];
                rcktm_pkg::REG_SCALE_DIVISOR: scale_reg  = v[4:0];
                rcktm_pkg::REG_ROTATION_MODE: rot_reg    = v[1:0];
                rcktm_pkg::REG_KEY_COLOR:     key_reg    = v[7:0];
                default: ;
            endcase
        endfunction

        function int side(int v);
            if (v == 0)
                return 1;
            if (v > MAX_SIDE_LEN)
                return MAX_SIDE_LEN;
            return v;
        endfunction

        // Source indices of the next pixel, counters wrapped to the current frame.
        function void source_indices(output int up, output int lo);
            int w, h, s, x, y;
            w = side(width_reg);
            h = side(height_reg);
            s = (scale_reg == 0) ? 1 : scale_reg;
            x = (col >= w) ? 0 : col;
            y = (row >= h) ? 0 : row;
            case (rot_reg)
                rcktm_pkg::ROT_NONE: begin
                    up = (w * y + x) / s;
                    lo = up;
                end
                rcktm_pkg::ROT_QUARTER: begin
                    up = (w * x + (h - 1 - y)) / s;
                    lo = (w * y + x) / s;
                end
                rcktm_pkg::ROT_HALF: begin
                    up = (w * (h - 1 - y) + (w - 1 - x)) / s;
                    lo = (w * y + x) / s;
                end
                default: begin
                    // three quarter turn: no scaling, may go negative on wide frames
                    up = w * (h - 1 - x) + y;
                    lo = w * y + x;
                end
            endcase
        endfunction

        function logic [TEX_W-1:0] read_tex(bit from_upper, int idx, inout bit err);
            if (idx < 0 || idx >= MAX_PIX) begin
                err = 1'b1;
                return key_reg[7:0];
            end
            if (from_upper)
                return upper_tex.exists(idx) ? upper_tex[idx] : '0;
            return lower_tex.exists(idx) ? lower_tex[idx] : '0;
        endfunction

        function void note_input(logic [1:0] cmd, logic [ADR_W-1:0] addr,
                                 logic [TEX_W-1:0] val);
            int               w, h, up, lo;
            bit               err;
            logic [TEX_W-1:0] c;
            t_pixel           p;
            if (cmd == rcktm_pkg::CMD_LOAD_LOWER) begin
                lower_tex[int'(addr)] = val;
            end else if (cmd == rcktm_pkg::CMD_LOAD_UPPER) begin
                upper_tex[int'(addr)] = val;
            end else if (cmd == rcktm_pkg::CMD_EMIT) begin
                w = side(width_reg);
                h = side(height_reg);
                if (col >= w)
                    col = 0;
                if (row >= h)
                    row = 0;
                source_indices(up, lo);
                err = 1'b0;
                c = read_tex(1'b1, up, err);
                if (c == key_reg[7:0])
                    c = read_tex(1'b0, lo, err);
                p.pixel = c;
                p.last  = (col == w - 1) && (row == h - 1);
                p.err   = err;
                if (col + 1 >= w) begin
                    col = 0;
                    row = (row + 1 >= h) ? 0 : row + 1;
                end else begin
                    col = col + 1;
                end
                due.push_back(p);
            end
        endfunction

        function void check_result(logic [TEX_W-1:0] pix, logic last, logic err);
            t_pixel exp_px;
            if (due.size() == 0) begin
                errors++;
                $display("%0t unexpected pixel: expected none actual %0h", $time, pix);
                return;
            end
            exp_px = due.pop_front();
            if (pix !== exp_px.pixel) begin
                errors++;
                $display("%0t merged_pixel mismatch: expected %0h actual %0h",
                         $time, exp_px.pixel, pix);
            end
            if (last !== exp_px.last) begin
                errors++;
                $display("%0t frame_last mismatch: expected %0b actual %0b",
                         $time, exp_px.last, last);
            end
            if (err !== exp_px.err) begin
                errors++;
                $display("%0t index_error mismatch: expected %0b actual %0b",
                         $time, exp_px.err, err);
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                push = 1'b0;
    logic                                full;
    logic [1:0]                          i_command = rcktm_pkg::CMD_LOAD_LOWER;
    logic [ADR_W-1:0]                    i_texel_address = '0;
    logic [TEX_W-1:0]                    i_texel_value = '0;
    logic                                empty;
    logic                                pop = 1'b0;
    logic [TEX_W-1:0]                    o_merged_pixel;
    logic                                o_frame_last;
    logic                                o_index_error;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [rcktm_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [rcktm_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [rcktm_pkg::APB_DATA_W-1:0]    prdata;
    logic                                pready;

    merge_scoreboard sb = new();
    bit              quiet = 1'b0;
    int              stall_count = 0;

    rotated_color_key_texture_merge_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_command       (i_command),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .empty           (empty),
        .pop             (pop),
        .o_merged_pixel  (o_merged_pixel),
        .o_frame_last    (o_frame_last),
        .o_index_error   (o_index_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= quiet || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_merged_pixel, o_frame_last, o_index_error);
    end

    // Runs only while nothing moves on either channel.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stall_count = 0;
        else
            stall_count = stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Entered and left at a falling edge; push stays high for back-to-back transactions.
    task automatic send(logic [1:0] cmd, logic [ADR_W-1:0] addr, logic [TEX_W-1:0] val);
        while (!quiet && $urandom_range(99) < 12) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_command       <= cmd;
        i_texel_address <= addr;
        i_texel_value   <= val;
        do
            @(posedge i_clk);
        while (full);
        sb.note_input(cmd, addr, val);
        @(negedge i_clk);
    endtask

    // Loads whatever the next pixel will read that has not been written yet, then emits it.
    task automatic emit_pixel();
        int               up, lo;
        bit               see_through;
        logic [TEX_W-1:0] v;
        sb.source_indices(up, lo);
        if (up >= 0 && up < MAX_PIX && !sb.upper_tex.exists(up)) begin
            v = ($urandom_range(2) == 0) ? sb.key_reg[7:0] : TEX_W'($urandom);
            send(rcktm_pkg::CMD_LOAD_UPPER, up[ADR_W-1:0], v);
        end
        see_through = 1'b1;
        if (up >= 0 && up < MAX_PIX)
            see_through = (sb.upper_tex[up] == sb.key_reg[7:0]);
        if (see_through && lo >= 0 && lo < MAX_PIX && !sb.lower_tex.exists(lo))
            send(rcktm_pkg::CMD_LOAD_LOWER, lo[ADR_W-1:0], TEX_W'($urandom));
        send(rcktm_pkg::CMD_EMIT, ADR_W'($urandom), TEX_W'($urandom));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        // loads leave no result behind, so give the back end time to settle
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Leaves the bus idle after the access so that back-to-back writes stay apart.
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int s, rcktm_pkg::t_rot rot, int key, int n_ops);
        int               r;
        int               span;
        logic [ADR_W-1:0] a;
        drain();
        write_reg(rcktm_pkg::REG_FRAME_WIDTH, 32'(w));
        write_reg(rcktm_pkg::REG_FRAME_HEIGHT, 32'(h));
        write_reg(rcktm_pkg::REG_SCALE_DIVISOR, 32'(s));
        write_reg(rcktm_pkg::REG_ROTATION_MODE, 32'(rot));
        write_reg(rcktm_pkg::REG_KEY_COLOR, 32'(key));
        span = sb.side(sb.width_reg) * sb.side(sb.height_reg);
        for (int i = 0; i < n_ops; i++) begin
            r = $urandom_range(99);
            if (r < 60) begin
                emit_pixel();
            end else if (r < 95) begin
                // overwrite texels in use, or anywhere in the store
                if ($urandom_range(1) == 0)
                    a = ADR_W'($urandom_range(span - 1));
                else
                    a = ADR_W'($urandom);
                send((r < 78) ? rcktm_pkg::CMD_LOAD_LOWER : rcktm_pkg::CMD_LOAD_UPPER, a,
                     ($urandom_range(3) == 0) ? sb.key_reg[7:0] : TEX_W'($urandom));
            end else begin
                send(CMD_UNUSED, ADR_W'($urandom), TEX_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: 64x64, no rotation, key 255
        send(rcktm_pkg::CMD_LOAD_UPPER, 16'hFFFF, 8'h00);
        send(rcktm_pkg::CMD_LOAD_LOWER, 16'hFFFF, 8'hFF);
        send(rcktm_pkg::CMD_LOAD_UPPER, 16'h0000, 8'hFF);
        send(rcktm_pkg::CMD_LOAD_LOWER, 16'h0000, 8'h5A);
        send(rcktm_pkg::CMD_EMIT, 16'h0000, 8'h00);
        send(rcktm_pkg::CMD_LOAD_UPPER, 16'h0001, 8'h00);
        send(rcktm_pkg::CMD_EMIT, 16'hFFFF, 8'hFF);
        send(CMD_UNUSED, 16'hFFFF, 8'hFF);
        send(rcktm_pkg::CMD_LOAD_UPPER, 16'h0002, 8'hFF);
        send(rcktm_pkg::CMD_LOAD_LOWER, 16'h0002, 8'hFF);
        send(rcktm_pkg::CMD_EMIT, 16'h5555, 8'hAA);
        repeat (6) emit_pixel();

        run_phase(4, 3, 1, rcktm_pkg::ROT_NONE, 0, 170);
        run_phase(0, 1, 0, rcktm_pkg::ROT_QUARTER, 255, 120);
        run_phase(5, 5, 2, rcktm_pkg::ROT_QUARTER, 7, 170);
        run_phase(6, 4, 3, rcktm_pkg::ROT_HALF, 200, 170);
        run_phase(8, 3, 1, rcktm_pkg::ROT_THREE_QUARTER, 1, 170);
        run_phase(3, 6, 1, rcktm_pkg::ROT_THREE_QUARTER, 128, 170);
        quiet = 1'b1;
        run_phase(256, 256, 16, rcktm_pkg::ROT_HALF, 255, 250);
        quiet = 1'b0;
        run_phase(511, 2, 31, rcktm_pkg::ROT_NONE, 64, 170);
        run_phase(256, 1, 1, rcktm_pkg::ROT_THREE_QUARTER, 0, 170);
        run_phase(1, 300, 17, rcktm_pkg::ROT_QUARTER, 3, 170);
        run_phase(7, 5, 1, rcktm_pkg::ROT_NONE, 255, 170);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
